FILE: hw/rtl/csu_pkg.sv
// csu_pkg: shared types and fixed constants of the column projection segmenter
// used by the lane encoders, the merge stage, the segment tracker and the top level
`default_nettype none

package csu_pkg;

    // fixed field widths
    localparam int DATA_W     = 64;
    localparam int ROW_W      = 6;
    localparam int COORD_W    = 10;
    localparam int HEIGHT_W   = 7;

    // lane split of one column
    localparam int LANES      = 8;
    localparam int LANE_W     = 8;
    localparam int LANE_IDX_W = 3;
    localparam int LANE_BIT_W = 3;

    // what one lane finds in its slice of rows
    typedef struct packed {
        logic                  any;
        logic [LANE_BIT_W-1:0] lo;
        logic [LANE_BIT_W-1:0] hi;
    } lane_info_t;

    // what the whole column holds
    typedef struct packed {
        logic             any;
        logic [ROW_W-1:0] lo;
        logic [ROW_W-1:0] hi;
    } col_info_t;

    // one column request handed to the tracker
    typedef struct packed {
        logic      valid;
        logic      first;
        col_info_t col;
    } step_t;

endpackage

`default_nettype wire

FILE: hw/rtl/csu_lane.sv
// csu_lane: lowest and highest set bit of one eight-row slice of a column
// depends on csu_pkg
`default_nettype none

module csu_lane
    import csu_pkg::*;
(
    input  wire logic [LANE_W-1:0] lane_bits,
    output lane_info_t             info
);

    // priority encoders in both directions
    always_comb
    begin
        info.any = |lane_bits;
        info.lo  = '0;
        info.hi  = '0;
        for (int i = LANE_W - 1; i >= 0; i--)
        begin
            if (lane_bits[i])
            begin
                info.lo = LANE_BIT_W'(i);
            end
        end
        for (int i = 0; i < LANE_W; i++)
        begin
            if (lane_bits[i])
            begin
                info.hi = LANE_BIT_W'(i);
            end
        end
    end

endmodule

`default_nettype wire

FILE: hw/rtl/csu_merge.sv
// csu_merge: combines the lane results into the column's top and bottom set rows
// depends on csu_pkg
`default_nettype none

module csu_merge
    import csu_pkg::*;
(
    input  lane_info_t lanes [LANES],
    output col_info_t  col
);

    // lowest lane with a set bit gives the top row, highest gives the bottom
    always_comb
    begin
        col.any = 1'b0;
        col.lo  = '0;
        col.hi  = '0;
        for (int i = LANES - 1; i >= 0; i--)
        begin
            if (lanes[i].any)
            begin
                col.lo = {LANE_IDX_W'(i), lanes[i].lo};
            end
        end
        for (int i = 0; i < LANES; i++)
        begin
            if (lanes[i].any)
            begin
                col.any = 1'b1;
                col.hi  = {LANE_IDX_W'(i), lanes[i].hi};
            end
        end
    end

endmodule

`default_nettype wire

FILE: hw/rtl/csu_tracker.sv
// csu_tracker: open segment state, column counter and the result register
// depends on csu_pkg
`default_nettype none

module csu_tracker
    import csu_pkg::*;
#(
    parameter int COLS = 1024
)
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  step_t                    step,
    output logic                     ready,
    output logic                     out_valid,
    input  wire logic                out_stall,
    output logic [COORD_W-1:0]       seg_x_start,
    output logic [COORD_W-1:0]       seg_width,
    output logic [ROW_W-1:0]         seg_top,
    output logic [HEIGHT_W-1:0]      seg_height
);

    localparam int CW = $clog2(COLS);
    localparam logic [CW-1:0] LAST_COL = CW'(COLS - 1);

    logic                in_seg_reg,  in_seg_next;
    logic [CW-1:0]       start_reg,   start_next;
    logic [ROW_W-1:0]    top_reg,     top_next;
    logic [ROW_W-1:0]    bot_reg,     bot_next;
    logic [CW-1:0]       col_reg,     col_next;
    logic                out_valid_reg, out_valid_next;
    logic [COORD_W-1:0]  x_start_reg, x_start_next;
    logic [COORD_W-1:0]  width_reg,   width_next;
    logic [ROW_W-1:0]    otop_reg,    otop_next;
    logic [HEIGHT_W-1:0] height_reg,  height_next;

    logic                proc;
    logic                cur_in;
    logic [CW-1:0]       cur_start;
    logic [ROW_W-1:0]    cur_top;
    logic [ROW_W-1:0]    cur_bot;
    logic [CW-1:0]       x;
    logic [CW-1:0]       width;
    logic [HEIGHT_W-1:0] height;
    logic [CW+COORD_W-1:0] width_ext;
    logic [CW+COORD_W-1:0] start_ext;

    // a request moves on when the result slot is free or being drained
    assign ready = !out_valid_reg || !out_stall;
    assign proc  = step.valid && ready;

    // first column flag clears the state before the column is used
    assign cur_in    = in_seg_reg && !step.first;
    assign cur_start = step.first ? '0 : start_reg;
    assign cur_top   = step.first ? '0 : top_reg;
    assign cur_bot   = step.first ? '0 : bot_reg;
    assign x         = step.first ? '0 : col_reg;

    // box of the segment that this column would close
    assign width     = x - cur_start;
    assign height    = {1'b0, cur_bot} - {1'b0, cur_top} + HEIGHT_W'(1);
    assign width_ext = {{COORD_W{1'b0}}, width};
    assign start_ext = {{COORD_W{1'b0}}, cur_start};

    // segment tracking and result load
    always_comb
    begin
        in_seg_next    = in_seg_reg;
        start_next     = start_reg;
        top_next       = top_reg;
        bot_next       = bot_reg;
        col_next       = col_reg;
        out_valid_next = out_valid_reg && out_stall;
        x_start_next   = x_start_reg;
        width_next     = width_reg;
        otop_next      = otop_reg;
        height_next    = height_reg;
        if (proc)
        begin
            in_seg_next = cur_in;
            start_next  = cur_start;
            top_next    = cur_top;
            bot_next    = cur_bot;
            col_next    = (x < LAST_COL) ? x + CW'(1) : x;
            if (step.col.any)
            begin
                if (!cur_in)
                begin
                    in_seg_next = 1'b1;
                    start_next  = x;
                    top_next    = step.col.lo;
                    bot_next    = step.col.hi;
                end
                else
                begin
                    top_next = (step.col.lo < cur_top) ? step.col.lo : cur_top;
                    bot_next = (step.col.hi > cur_bot) ? step.col.hi : cur_bot;
                end
            end
            else if (cur_in)
            begin
                if (height > HEIGHT_W'(1) && width > CW'(1))
                begin
                    out_valid_next = 1'b1;
                    x_start_next   = start_ext[COORD_W-1:0];
                    width_next     = width_ext[COORD_W-1:0];
                    otop_next      = cur_top;
                    height_next    = height;
                end
                in_seg_next = 1'b0;
                start_next  = '0;
                top_next    = '0;
                bot_next    = '0;
            end
        end
    end

    // control and segment state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_seg_reg    <= 1'b0;
            start_reg     <= '0;
            top_reg       <= '0;
            bot_reg       <= '0;
            col_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_seg_reg    <= in_seg_next;
            start_reg     <= start_next;
            top_reg       <= top_next;
            bot_reg       <= bot_next;
            col_reg       <= col_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // result payload
    always_ff @(posedge clk)
    begin
        x_start_reg <= x_start_next;
        width_reg   <= width_next;
        otop_reg    <= otop_next;
        height_reg  <= height_next;
    end

    assign out_valid   = out_valid_reg;
    assign seg_x_start = x_start_reg;
    assign seg_width   = width_reg;
    assign seg_top     = otop_reg;
    assign seg_height  = height_reg;

endmodule

`default_nettype wire

FILE: hw/rtl/column_projection_segmenter_unit.sv
// Column projection segmenter. Takes one column of a binary image per cycle,
// left to right, and reports the bounding box of each run of non-empty columns
// once the following empty column closes it, if the box is at least two wide
// and two high. A column enters every cycle; a closing column passes the lane stage
// register, then loads the result register. The rate is set by the segment update
// in the tracker, fed by eight lane encoders whose results are registered and
// merged. The input stalls only while its stage register is full and the result
// register holds an untaken result. Rows at or above ROWS are ignored; the
// column counter stops at COLS-1 and positions are reported in their low ten bits.
// depends on csu_pkg, csu_lane, csu_merge, csu_tracker
`default_nettype none

module column_projection_segmenter_unit
    import csu_pkg::*;
#(
    parameter int ROWS = 64,
    parameter int COLS = 1024
)
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                in_valid,
    output logic                     in_stall,
    input  wire logic [DATA_W-1:0]   column_bits,
    input  wire logic                first_column,
    output logic                     out_valid,
    input  wire logic                out_stall,
    output logic [COORD_W-1:0]       seg_x_start,
    output logic [COORD_W-1:0]       seg_width,
    output logic [ROW_W-1:0]         seg_top,
    output logic [HEIGHT_W-1:0]      seg_height
);

    logic [DATA_W-1:0] row_mask;
    logic [DATA_W-1:0] masked_bits;
    lane_info_t        lane_info [LANES];
    lane_info_t        lanes_reg [LANES];
    logic              s1_valid_reg, s1_valid_next;
    logic              s1_first_reg;
    logic              in_take;
    logic              trk_ready;
    col_info_t         col;
    step_t             step;

    // keep only the rows that exist
    always_comb
    begin
        for (int r = 0; r < DATA_W; r++)
        begin
            row_mask[r] = (r < ROWS);
        end
    end
    assign masked_bits = column_bits & row_mask;

    // lane encoders
    for (genvar g = 0; g < LANES; g++)
    begin : g_lane
        csu_lane u_lane
        (
            .lane_bits (masked_bits[g*LANE_W +: LANE_W]),
            .info      (lane_info[g])
        );
    end

    // lane stage register
    assign in_stall      = s1_valid_reg && !trk_ready;
    assign in_take       = in_valid && !in_stall;
    assign s1_valid_next = in_stall ? s1_valid_reg : in_valid;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            lanes_reg    <= lane_info;
            s1_first_reg <= first_column;
        end
    end

    // merge lanes into one column summary
    csu_merge u_merge
    (
        .lanes (lanes_reg),
        .col   (col)
    );

    assign step.valid = s1_valid_reg;
    assign step.first = s1_first_reg;
    assign step.col   = col;

    // segment tracking and result register
    csu_tracker #(
        .COLS (COLS)
    ) u_tracker
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .step        (step),
        .ready       (trk_ready),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .seg_x_start (seg_x_start),
        .seg_width   (seg_width),
        .seg_top     (seg_top),
        .seg_height  (seg_height)
    );

endmodule

`default_nettype wire

FILE: hw/rtl/csu_checker.sv
// csu_checker: port-level checks of the column projection segmenter, and its bind
// depends on csu_pkg and column_projection_segmenter_unit
`default_nettype none

module csu_checker
    import csu_pkg::*;
#(
    parameter int ROWS = 64
)
(
    input wire logic                clk,
    input wire logic                rst_n,
    input wire logic                in_stall,
    input wire logic                out_valid,
    input wire logic                out_stall,
    input wire logic [COORD_W-1:0]  seg_x_start,
    input wire logic [COORD_W-1:0]  seg_width,
    input wire logic [ROW_W-1:0]    seg_top,
    input wire logic [HEIGHT_W-1:0] seg_height
);

    // a stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(seg_x_start) && $stable(seg_width)
            && $stable(seg_top) && $stable(seg_height))
        else $error("stalled result changed");

    // input backs up only behind a held result
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid && out_stall)
        else $error("input stalled while output free");

    // reported height is two or more and within the rows
    a_height: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> seg_height >= HEIGHT_W'(2) && seg_height <= HEIGHT_W'(ROWS))
        else $error("segment height out of range");

    // box stays inside the rows
    a_box_rows: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> ({1'b0, seg_top} + seg_height) <= HEIGHT_W'(ROWS))
        else $error("segment box beyond last row");

endmodule

bind column_projection_segmenter_unit csu_checker #(
    .ROWS (ROWS)
) u_csu_checker
(
    .clk         (clk),
    .rst_n       (rst_n),
    .in_stall    (in_stall),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .seg_x_start (seg_x_start),
    .seg_width   (seg_width),
    .seg_top     (seg_top),
    .seg_height  (seg_height)
);

`default_nettype wire
